>>> rtl/core/dfe_pkg.sv
package dfe_pkg;

  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_DELIM_BYTES = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DELIM_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FIELD_NUM   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FIELD_CAP   = 2'd3;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_PAD     = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [7:0] NUL_BYTE      = 8'h00;
  localparam logic [7:0] LEN_SATURATED = 8'hFF;
  localparam logic [5:0] CAP_RESET     = 6'd32;
  localparam int unsigned SLOT_LIMIT   = 4;

  typedef enum logic [1:0] {
    PH_COUNT     = 2'd0,
    PH_COPY      = 2'd1,
    PH_SKIP_DONE = 2'd2,
    PH_SKIP_FAIL = 2'd3
  } phase_t;

  typedef struct packed {
    logic hit;
    logic set_empty;
  } match_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] length;
    logic       found;
    logic       last;
  } result_t;

endpackage

>>> rtl/core/delimited_field_extractor.sv
// path: an accepted input beat goes through the input register and then the result register to m_*
// throughput: 1 input beat per cycle while results drain; a byte that closes
//   the field holds the input register for (capacity - copied bytes) pad beats
//   plus one summary beat, one result per cycle from the single emit path
// reset: synchronous rst clears the field state, both pipeline registers and
//   the configuration registers (capacity returns to 32, delimiter set empty)
module delimited_field_extractor
  import dfe_pkg::*;
#(
  parameter int unsigned MAX_FIELD_BYTES = 32,
  parameter int unsigned DELIMITER_SLOTS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // char_in[7:0]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [23:0]            m_tdata,   // data_byte[7:0], field_length[15:8], found[16]
  output logic [1:0]             m_tuser,   // item_kind[1:0]
  output logic                   m_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [CFG_DATA_W-1:0] delim_bytes;
  logic [2:0]            delim_count;
  logic [7:0]            field_number;
  logic [5:0]            field_capacity;

  logic       in_valid;
  logic [7:0] in_byte;

  logic    out_valid;
  result_t out_res;
  logic    out_take;

  logic    emit;
  logic    done;
  logic    act;
  result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delim_bytes    <= '0;
      delim_count    <= 3'd0;
      field_number   <= 8'd0;
      field_capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DELIM_BYTES: delim_bytes    <= cfg_data;
        REG_DELIM_COUNT: delim_count    <= cfg_data[2:0];
        REG_FIELD_NUM:   field_number   <= cfg_data[7:0];
        REG_FIELD_CAP:   field_capacity <= cfg_data[5:0];
      endcase
    end
  end

  assign out_take = !out_valid || m_tready;
  assign s_tready = !in_valid || (act && done);

  dfe_ctrl #(
    .MAX_FIELD_BYTES(MAX_FIELD_BYTES),
    .DELIMITER_SLOTS(DELIMITER_SLOTS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_byte       (in_byte),
    .out_take      (out_take),
    .delim_bytes   (delim_bytes),
    .delim_count   (delim_count),
    .field_number  (field_number),
    .field_capacity(field_capacity),
    .emit          (emit),
    .done          (done),
    .act           (act),
    .res           (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (act && emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (act && emit) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_res.found, out_res.length, out_res.data};
  assign m_tuser  = out_res.kind;
  assign m_tlast  = out_res.last;

endmodule

>>> rtl/core/dfe_match.sv
module dfe_match
  import dfe_pkg::*;
#(
  parameter int unsigned DELIMITER_SLOTS = 4
) (
  input  logic [CFG_DATA_W-1:0] delim_bytes,
  input  logic [2:0]            delim_count,
  input  logic [7:0]            char_byte,
  output match_t                match
);

  localparam int unsigned LIVE = (DELIMITER_SLOTS < SLOT_LIMIT) ? DELIMITER_SLOTS : SLOT_LIMIT;

  logic [3:0] active;

  always_comb begin
    active = ({1'b0, delim_count} > 4'(DELIMITER_SLOTS)) ? 4'(DELIMITER_SLOTS)
                                                         : {1'b0, delim_count};
    match.hit       = 1'b0;
    match.set_empty = 1'b1;
    for (int i = 0; i < LIVE; i++) begin
      if (4'(i) < active) begin
        if (delim_bytes[8*i +: 8] != NUL_BYTE) begin
          match.set_empty = 1'b0;
        end
        if (delim_bytes[8*i +: 8] == char_byte && char_byte != NUL_BYTE) begin
          match.hit = 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/dfe_ctrl.sv
module dfe_ctrl
  import dfe_pkg::*;
#(
  parameter int unsigned MAX_FIELD_BYTES = 32,
  parameter int unsigned DELIMITER_SLOTS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [7:0]            in_byte,
  input  logic                  out_take,
  input  logic [CFG_DATA_W-1:0] delim_bytes,
  input  logic [2:0]            delim_count,
  input  logic [7:0]            field_number,
  input  logic [5:0]            field_capacity,
  output logic                  emit,
  output logic                  done,
  output logic                  act,
  output result_t               res
);

  localparam int unsigned CW = $clog2(MAX_FIELD_BYTES + 1);

  phase_t        phase, phase_next;
  logic [7:0]    seen, seen_next;
  logic [7:0]    bytes, bytes_next;
  logic [CW-1:0] cnt, cnt_next;

  match_t        match;
  logic [CW-1:0] cap;
  logic          eff_copy;
  logic [7:0]    eff_bytes;
  logic [CW-1:0] eff_cnt;
  logic          term;
  logic          clear_run;
  logic [7:0]    seen_inc;

  dfe_match #(
    .DELIMITER_SLOTS(DELIMITER_SLOTS)
  ) u_match (
    .delim_bytes(delim_bytes),
    .delim_count(delim_count),
    .char_byte  (in_byte),
    .match      (match)
  );

  always_comb begin
    cap = ({1'b0, field_capacity} > 7'(MAX_FIELD_BYTES)) ? CW'(MAX_FIELD_BYTES)
                                                         : field_capacity[CW-1:0];
    eff_copy  = (phase == PH_COPY) || (phase == PH_COUNT && seen >= field_number);
    eff_bytes = (phase == PH_COPY) ? bytes : 8'd0;
    eff_cnt   = (phase == PH_COPY) ? cnt : '0;
    term      = (in_byte == NUL_BYTE);
    seen_inc  = seen + 8'd1;

    phase_next = phase;
    seen_next  = seen;
    bytes_next = bytes;
    cnt_next   = cnt;
    clear_run  = 1'b0;
    emit       = 1'b0;
    done       = 1'b1;
    res        = '{kind: KIND_BYTE, data: NUL_BYTE, length: 8'd0, found: 1'b0, last: 1'b0};

    if ((phase == PH_COUNT || phase == PH_COPY) && match.set_empty) begin
      if (term) begin
        emit      = 1'b1;
        res.kind  = KIND_SUMMARY;
        res.last  = 1'b1;
        clear_run = 1'b1;
      end else begin
        phase_next = PH_SKIP_FAIL;
      end
    end else if (eff_copy) begin
      if (term || match.hit) begin
        emit = 1'b1;
        if (eff_cnt < cap) begin
          res.kind   = KIND_PAD;
          done       = 1'b0;
          phase_next = PH_COPY;
          bytes_next = eff_bytes;
          cnt_next   = CW'(eff_cnt + 1'b1);
        end else begin
          res.kind   = KIND_SUMMARY;
          res.length = eff_bytes;
          res.found  = 1'b1;
          res.last   = 1'b1;
          if (term) begin
            clear_run = 1'b1;
          end else begin
            phase_next = PH_SKIP_DONE;
          end
        end
      end else begin
        phase_next = PH_COPY;
        if (eff_cnt < cap) begin
          emit     = 1'b1;
          res.kind = KIND_BYTE;
          res.data = in_byte;
        end
        bytes_next = (eff_bytes == LEN_SATURATED) ? eff_bytes : eff_bytes + 8'd1;
        cnt_next   = (eff_cnt < CW'(MAX_FIELD_BYTES)) ? CW'(eff_cnt + 1'b1) : eff_cnt;
      end
    end else begin
      unique case (phase)
        PH_COUNT: begin
          if (term) begin
            emit      = 1'b1;
            res.kind  = KIND_SUMMARY;
            res.last  = 1'b1;
            clear_run = 1'b1;
          end else if (match.hit) begin
            seen_next = seen_inc;
            if (seen_inc >= field_number) begin
              phase_next = PH_COPY;
              bytes_next = 8'd0;
              cnt_next   = '0;
            end
          end
        end
        PH_SKIP_DONE: begin
          if (term) begin
            clear_run = 1'b1;
          end
        end
        PH_SKIP_FAIL: begin
          if (term) begin
            emit      = 1'b1;
            res.kind  = KIND_SUMMARY;
            res.last  = 1'b1;
            clear_run = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (clear_run) begin
      phase_next = PH_COUNT;
      seen_next  = 8'd0;
      bytes_next = 8'd0;
      cnt_next   = '0;
    end

    act = in_valid && (out_take || !emit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_COUNT;
      seen  <= 8'd0;
      bytes <= 8'd0;
      cnt   <= '0;
    end else if (act) begin
      phase <= phase_next;
      seen  <= seen_next;
      bytes <= bytes_next;
      cnt   <= cnt_next;
    end
  end

endmodule

>>> rtl/core/dfe_checker.sv
module dfe_checker
  import dfe_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // no result beat right after reset
  a_idle_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat right after reset");

  // last marks summaries only, and every summary closes a run
  a_last_is_summary: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == KIND_SUMMARY)))
    else $error("last and summary kind disagree");

  // length and found only on summaries, pads carry zero data
  a_summary_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_SUMMARY |-> m_tdata[16:8] == 9'd0 &&
      (m_tuser != KIND_PAD || m_tdata[7:0] == 8'd0))
    else $error("summary fields on a non-summary beat");

  // not-found summary carries zero length
  a_not_found_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_SUMMARY && !m_tdata[16] |-> m_tdata[15:0] == 16'd0)
    else $error("not-found summary with nonzero length");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
      $stable(m_tlast))
    else $error("stalled result beat changed");

endmodule

bind delimited_field_extractor dfe_checker u_dfe_checker (.*);

>>> tb/delimited_field_extractor_tb.sv
`timescale 1ns / 100ps

module delimited_field_extractor_tb
  import dfe_pkg::*;
;

  localparam int unsigned FIELD_BYTES_MAX = 32;
  localparam int unsigned QUIET_LIMIT     = 1000;
  localparam int unsigned HOLD_CYCLES     = 300;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [23:0]            m_tdata;
  logic [1:0]             m_tuser;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // register copies
  logic [31:0] delim_word     = '0;
  logic [2:0]  delim_slots    = '0;
  logic [7:0]  wanted_field   = '0;
  logic [5:0]  capacity_bytes = CAP_RESET;

  // scanner state
  phase_t      scan_phase    = PH_COUNT;
  logic [7:0]  delims_passed = '0;
  logic [7:0]  field_len     = '0;

  logic [7:0]  string_chars[$];
  result_t     field_out_q[$];

  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap     = 0;
  int unsigned recv_gap     = 0;
  int unsigned hold_left    = 0;
  bit          hold_armed   = 1'b0;
  bit          hold_done    = 1'b0;
  bit          calm         = 1'b0;
  result_t     want_beat;
  logic        ready_next;

  delimited_field_extractor #(
    .MAX_FIELD_BYTES(FIELD_BYTES_MAX),
    .DELIMITER_SLOTS(SLOT_LIMIT)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned live_slots();
    return (delim_slots > SLOT_LIMIT) ? SLOT_LIMIT : delim_slots;
  endfunction

  function automatic bit no_live_delims();
    int unsigned i;
    for (i = 0; i < live_slots(); i++) begin
      if (delim_word[8*i +: 8] != NUL_BYTE) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit is_delim(logic [7:0] ch);
    int unsigned i;
    if (ch == NUL_BYTE) return 1'b0;
    for (i = 0; i < live_slots(); i++) begin
      if (delim_word[8*i +: 8] == ch) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void push_result(logic [1:0] kind, logic [7:0] data, logic [7:0] len,
                                      logic fnd);
    result_t r;
    r.kind   = kind;
    r.data   = data;
    r.length = len;
    r.found  = fnd;
    r.last   = (kind == KIND_SUMMARY);
    field_out_q.push_back(r);
  endfunction

  function automatic void restart_scan();
    scan_phase    = PH_COUNT;
    delims_passed = '0;
    field_len     = '0;
  endfunction

  // expected output beats for one accepted input byte
  function automatic void extract_char(logic [7:0] ch);
    int unsigned cap;
    int unsigned i;
    cap = (capacity_bytes > FIELD_BYTES_MAX) ? FIELD_BYTES_MAX : capacity_bytes;
    if ((scan_phase == PH_COUNT || scan_phase == PH_COPY) && no_live_delims()) begin
      if (ch == NUL_BYTE) begin
        push_result(KIND_SUMMARY, 8'd0, 8'd0, 1'b0);
        restart_scan();
      end else begin
        scan_phase = PH_SKIP_FAIL;
      end
      return;
    end
    if (scan_phase == PH_COUNT && delims_passed >= wanted_field) begin
      scan_phase = PH_COPY;
      field_len  = '0;
    end
    case (scan_phase)
      PH_COUNT: begin
        if (ch == NUL_BYTE) begin
          push_result(KIND_SUMMARY, 8'd0, 8'd0, 1'b0);
          restart_scan();
        end else if (is_delim(ch)) begin
          delims_passed = delims_passed + 8'd1;
          if (delims_passed >= wanted_field) begin
            scan_phase = PH_COPY;
            field_len  = '0;
          end
        end
      end
      PH_COPY: begin
        if (ch == NUL_BYTE || is_delim(ch)) begin
          for (i = 32'(field_len); i < cap; i++) push_result(KIND_PAD, 8'd0, 8'd0, 1'b0);
          push_result(KIND_SUMMARY, 8'd0, field_len, 1'b1);
          if (ch == NUL_BYTE) restart_scan();
          else scan_phase = PH_SKIP_DONE;
        end else begin
          if (field_len < cap) push_result(KIND_BYTE, ch, 8'd0, 1'b0);
          if (field_len < LEN_SATURATED) field_len = field_len + 8'd1;
        end
      end
      PH_SKIP_DONE: begin
        if (ch == NUL_BYTE) restart_scan();
      end
      default: begin
        if (ch == NUL_BYTE) begin
          push_result(KIND_SUMMARY, 8'd0, 8'd0, 1'b0);
          restart_scan();
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) extract_char(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (string_chars.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= string_chars.pop_front();
          if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 12);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (field_out_q.size() == 0) begin
          $error("item_kind expected none actual %0d", m_tuser);
          mismatches++;
        end else begin
          want_beat = field_out_q.pop_front();
          check_field("item_kind", {6'd0, want_beat.kind}, {6'd0, m_tuser});
          check_field("data_byte", want_beat.data, m_tdata[7:0]);
          check_field("field_length", want_beat.length, m_tdata[15:8]);
          check_field("found", {7'd0, want_beat.found}, {7'd0, m_tdata[16]});
          check_field("last", {7'd0, want_beat.last}, {7'd0, m_tlast});
        end
      end
      ready_next = 1'b1;
      if (hold_armed && !hold_done && m_tvalid) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        ready_next = 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_gap   = $urandom_range(0, 11);
        ready_next = 1'b0;
      end
      m_tready <= ready_next;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("delimited_field_extractor: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DELIM_BYTES: delim_word     = value;
      REG_DELIM_COUNT: delim_slots    = value[2:0];
      REG_FIELD_NUM:   wanted_field   = value[7:0];
      REG_FIELD_CAP:   capacity_bytes = value[5:0];
      default: ;
    endcase
  endtask

  task automatic setup_extract(input logic [31:0] delims, input logic [2:0] slots,
                               input logic [7:0] field, input logic [5:0] cap);
    write_reg(REG_DELIM_BYTES, delims);
    write_reg(REG_DELIM_COUNT, {29'd0, slots});
    write_reg(REG_FIELD_NUM, {24'd0, field});
    write_reg(REG_FIELD_CAP, {26'd0, cap});
  endtask

  task automatic random_setup();
    logic [31:0] delims;
    logic [5:0]  cap;
    int unsigned i;
    for (i = 0; i < 4; i++) begin
      delims[8*i +: 8] = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    end
    case ($urandom_range(0, 4))
      0:       cap = 6'd0;
      1:       cap = 6'd32;
      2:       cap = 6'd63;
      default: cap = 6'($urandom_range(1, 8));
    endcase
    setup_extract(delims, 3'($urandom_range(1, 4)), 8'($urandom_range(0, 3)), cap);
  endtask

  // wait until the block has nothing left to say
  task automatic drain();
    @(negedge clk);
    while (string_chars.size() != 0 || s_tvalid || field_out_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic queue_text(input string s);
    int unsigned i;
    for (i = 0; i < s.len(); i++) string_chars.push_back(s[i]);
    string_chars.push_back(NUL_BYTE);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(1, 255)); while (is_delim(ch));
    return ch;
  endfunction

  function automatic logic [7:0] pick_delim();
    logic [7:0]  pool[$];
    int unsigned i;
    for (i = 0; i < live_slots(); i++) begin
      if (delim_word[8*i +: 8] != NUL_BYTE) pool.push_back(delim_word[8*i +: 8]);
    end
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  task automatic queue_record(input int unsigned nfields, input int unsigned longest);
    int unsigned f;
    int unsigned len;
    for (f = 0; f < nfields; f++) begin
      if (f > 0 && !no_live_delims()) string_chars.push_back(pick_delim());
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, longest) : $urandom_range(0, 5);
      repeat (len) string_chars.push_back(plain_char());
    end
    string_chars.push_back(NUL_BYTE);
  endtask

  task automatic random_phase(input int unsigned items, input int unsigned longest);
    int unsigned pushed;
    int unsigned was;
    int unsigned deep;
    pushed = 0;
    deep   = (wanted_field > 4) ? 4 : wanted_field;
    @(negedge clk);
    while (pushed < items) begin
      was = string_chars.size();
      if ($urandom_range(0, 6) == 0) begin
        // raw bytes, stray zeros and delimiters included
        repeat ($urandom_range(1, 10)) string_chars.push_back(8'($urandom_range(0, 255)));
        string_chars.push_back(NUL_BYTE);
      end else begin
        queue_record($urandom_range(0, deep + 3), longest);
      end
      pushed += string_chars.size() - was;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset config has no delimiters
    @(negedge clk);
    queue_text("ab");
    queue_text("");
    drain();

    // zero slot, capacity zero, field zero
    setup_extract(32'h01FF2C00, 3'd4, 8'd0, 6'd0);
    @(negedge clk);
    queue_text("x,");
    queue_text("");
    string_chars.push_back(8'h01);
    queue_text("a");
    drain();

    // slot count and capacity past their limits, early end of string
    setup_extract(32'h01FF2C00, 3'd7, 8'd2, 6'd63);
    @(negedge clk);
    queue_text("a,b");
    string_chars.push_back("a");
    string_chars.push_back(8'hFF);
    string_chars.push_back("b");
    string_chars.push_back(8'h01);
    string_chars.push_back(8'h80);
    string_chars.push_back(8'h7F);
    string_chars.push_back(NUL_BYTE);
    drain();

    // only active slot holds zero
    setup_extract(32'h2C2C2C00, 3'd1, 8'd0, 6'd32);
    @(negedge clk);
    queue_text("q,");
    drain();

    setup_extract({16'd0, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))},
                  3'd2, 8'd255, 6'd5);
    random_phase(3, 8);
    drain();

    // long receiver stall while the sender keeps pushing
    setup_extract(32'hFFFFFFFF, 3'd4, 8'd1, 6'd32);
    random_phase(12, 12);
    hold_armed = 1'b1;
    drain();

    repeat (2) begin
      random_setup();
      random_phase(8, 12);
      drain();
    end

    // field longer than the length counter
    setup_extract(32'h0000002C, 3'd1, 8'd0, 6'd4);
    @(negedge clk);
    repeat (256) string_chars.push_back(plain_char());
    string_chars.push_back(NUL_BYTE);
    drain();

    calm = 1'b1;
    random_setup();
    random_phase(5, 8);
    drain();

    repeat (10) @(posedge clk);
    if (mismatches == 0 && field_out_q.size() == 0) begin
      $display("delimited_field_extractor: match");
    end else begin
      $display("delimited_field_extractor: mismatch");
    end
    $finish;
  end

endmodule
